>>> rtl/sorted_priority_queue_unit_defines.svh
// ----------------------------------------------------------------------------
// sorted priority queue assertion macros
// shared concurrent assertion forms clocked on aclk, held off during reset
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// property that must hold at every edge
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// types, codes and key compare shared by the priority queue cells and top
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int TAG_W    = 32;
    localparam int PRIO_W   = 8;
    localparam int ORDER_W  = 16;
    localparam int STATUS_W = 2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // tag in the low bits
    typedef struct packed {
        logic [ORDER_W-1:0] order;
        logic [PRIO_W-1:0]  prio;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ctl_t;

    typedef struct packed {
        logic   valid;
        logic   after;
        entry_t entry;
    } link_t;

    // held entry must be served after the new key
    function automatic logic goes_after(entry_t held, entry_t key);
        logic res;
        if (held.prio != key.prio) begin
            res = held.prio > key.prio;
        end else begin
            res = held.order > key.order;
        end
        return res;
    endfunction

endpackage

>>> rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds an entry, compares it with a new key,
// takes the new entry, its upper neighbor or its lower neighbor
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  spq_pkg::ctl_t   ctl,
    input  spq_pkg::entry_t new_entry,
    input  spq_pkg::link_t  prev,
    input  spq_pkg::link_t  next,
    output spq_pkg::link_t  self
);
    import spq_pkg::*;

    logic   valid_reg, valid_next;
    entry_t entry_reg, entry_next;
    logic   after;

    assign after = !valid_reg || goes_after(entry_reg, new_entry);

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctl.push) begin
            if (prev.after) begin
                valid_next = prev.valid;
                entry_next = prev.entry;
            end else if (after) begin
                valid_next = 1'b1;
                entry_next = new_entry;
            end
        end else if (ctl.pop) begin
            valid_next = next.valid;
            entry_next = next.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end

    assign self.valid = valid_reg;
    assign self.after = after;
    assign self.entry = entry_reg;

endmodule

>>> rtl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// bounded priority queue kept sorted in a chain of cells; lower priority
// first, ties in ascending arrival order
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                    | tuser
//  s_       | in  | job_tag, priority_req, arrival_order  | cmd
//  m_       | out | out_tag, out_priority, out_order, status | -
//
//  one item per cycle while s_tready is high: every cell compares its key
//  with the pushed key in parallel and shifts one place on a push or pop;
//  result registered in the output stage; s_tready is high while it is empty
//  or being taken
//  aresetn clears the cell valid bits and the output valid, queue empty
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit #(
    parameter int DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // job_tag, priority_req, arrival_order
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // out_tag, out_priority, out_order, status
);
    import spq_pkg::*;

    link_t             links [DEPTH];
    link_t             head_prev, tail_next;
    logic [DEPTH-1:0]  valid_vec;
    ctl_t              ctl;
    entry_t            new_entry;
    logic              accept, full, empty;

    logic              m_tvalid_reg;
    entry_t            res_entry_reg, res_entry_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    assign new_entry = s_tdata;
    assign accept    = s_tvalid && s_tready;
    assign full      = valid_vec[DEPTH-1];
    assign empty     = !valid_vec[0];
    assign ctl.push  = accept && (s_tuser == CMD_PUSH) && !full;
    assign ctl.pop   = accept && (s_tuser == CMD_POP) && !empty;

    assign head_prev = '{valid: 1'b0, after: 1'b0, entry: '0};
    assign tail_next = '{valid: 1'b0, after: 1'b1, entry: '0};

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        spq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .new_entry (new_entry),
            .prev      ((i == 0) ? head_prev : links[(i == 0) ? 0 : i - 1]),
            .next      ((i == DEPTH - 1) ? tail_next
                                         : links[(i == DEPTH - 1) ? i : i + 1]),
            .self      (links[i])
        );
        assign valid_vec[i] = links[i].valid;
    end

    always_comb begin
        res_entry_next  = '0;
        res_status_next = STAT_OK;
        if (s_tuser == CMD_PUSH) begin
            if (full) begin
                res_status_next = STAT_FULL;
            end
        end else if (empty) begin
            res_status_next = STAT_EMPTY;
        end else begin
            res_entry_next = links[0].entry;
        end
    end

    assign s_tready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
        if (accept) begin
            res_entry_reg  <= res_entry_next;
            res_status_reg <= res_status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, res_status_reg, res_entry_reg};

    `SPQ_ASSERT_ALWAYS(a_valid_packed, (({1'b0, valid_vec} & ({1'b0, valid_vec} + (DEPTH+1)'(1))) == '0), "cell valid bits not packed at head")
    `SPQ_ASSERT_NEXT(a_full_refused, (accept && s_tuser == CMD_PUSH && full), (m_tvalid && m_tdata[57:56] == STAT_FULL && full), "push on full queue not refused")
    `SPQ_ASSERT_NEXT(a_pop_frees, (accept && s_tuser == CMD_POP && !empty), (!valid_vec[DEPTH-1] && m_tdata[57:56] == STAT_OK), "pop did not free a cell")

endmodule
